>>> hdl/frame_section_profiler_assert.svh
// frame_section_profiler_assert.svh
// assertion macros for the frame section profiler, clocked on clk_i
// and disabled while rst_ni is low; define ASSERT_OFF to drop them
`ifndef FRAME_SECTION_PROFILER_ASSERT_SVH
`define FRAME_SECTION_PROFILER_ASSERT_SVH
`ifndef ASSERT_OFF
`define FSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
`define FSP_ASSERT_NEVER(lbl, expr) \
  `FSP_ASSERT(lbl, !(expr))
`else
`define FSP_ASSERT(lbl, prop)
`define FSP_ASSERT_NEVER(lbl, expr)
`endif
`endif

>>> hdl/fsp_pkg.sv
// fsp_pkg.sv
// types and constants shared by the frame section profiler files
// no dependencies
package fsp_pkg;

  localparam int unsigned TICK_W    = 16;
  localparam int unsigned GRACE_W   = 8;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [TICK_W-1:0]  BUDGET_RESET = 16'd4389;
  localparam logic [GRACE_W-1:0] GRACE_RESET  = 8'd20;

  // request kinds
  localparam logic [2:0] KIND_FRAME = 3'd0;
  localparam logic [2:0] KIND_MARK  = 3'd1;
  localparam logic [2:0] KIND_LEVEL = 3'd2;
  localparam logic [2:0] KIND_CLEAR = 3'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRACE  = 4'd1;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [2:0]        kind;
    logic [3:0]        slot;
    logic [TICK_W-1:0] timer_now;
    logic              show_worst;
  } fsp_in_t;

  typedef struct packed {
    logic [TICK_W-1:0] slot_ticks;
    logic [TICK_W-1:0] frame_total;
    logic [TICK_W-1:0] overrun_count;
  } fsp_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] addr;
    logic [TICK_W-1:0]    wdata;
  } fsp_cfg_t;

  // slot bank write controls
  typedef struct packed {
    logic sec_wr;       // write section ticks at the address
    logic frame_move;   // copy section to previous and clear it
    logic worst_raise;  // copy section to worst
    logic worst_clear;  // clear every worst entry
  } bank_cmd_t;

endpackage

>>> hdl/fsp_if.sv
// fsp_if.sv
// valid/ready channel interfaces for input, result and configuration requests
// depends on fsp_pkg
interface fsp_in_if import fsp_pkg::*; ();
  logic    valid;
  logic    ready;
  fsp_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fsp_out_if import fsp_pkg::*; ();
  logic     valid;
  logic     ready;
  fsp_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fsp_cfg_if import fsp_pkg::*; ();
  logic     valid;
  logic     ready;
  fsp_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/fsp_alu.sv
// fsp_alu.sv
// shared add/subtract unit used by the sequencer for sums and compares
// depends on fsp_pkg
module fsp_alu import fsp_pkg::*; #(
  parameter int unsigned W = 19
) (
  input  alu_op_e        op_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [W-1:0]   res_o,
  output logic           carry_o
);

  logic         sub;
  logic [W:0]   full;

  assign sub = (op_i == ALU_SUB);
  // for a subtract, carry set means a >= b
  assign full = {1'b0, a_i} + {1'b0, b_i ^ {W{sub}}} + (W+1)'(sub);
  assign res_o   = full[W-1:0];
  assign carry_o = full[W];

endmodule

>>> hdl/fsp_slot_bank.sv
// fsp_slot_bank.sv
// per-slot section, previous and worst tick registers with one shared address
// depends on fsp_pkg
module fsp_slot_bank import fsp_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 8,
  parameter int unsigned IDX_W      = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bank_cmd_t         cmd_i,
  input  logic [IDX_W-1:0]  addr_i,
  input  logic [TICK_W-1:0] sec_wdata_i,
  output logic [TICK_W-1:0] sec_o,
  output logic [TICK_W-1:0] prev_o,
  output logic [TICK_W-1:0] worst_o
);

  logic [TICK_W-1:0] sec_q   [SLOT_COUNT];
  logic [TICK_W-1:0] prev_q  [SLOT_COUNT];
  logic [TICK_W-1:0] worst_q [SLOT_COUNT];

  assign sec_o   = sec_q[addr_i];
  assign prev_o  = prev_q[addr_i];
  assign worst_o = worst_q[addr_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        sec_q[i]   <= '0;
        prev_q[i]  <= '0;
        worst_q[i] <= '0;
      end
    end else begin
      if (cmd_i.sec_wr) begin
        sec_q[addr_i] <= sec_wdata_i;
      end
      if (cmd_i.frame_move) begin
        prev_q[addr_i] <= sec_q[addr_i];
        sec_q[addr_i]  <= '0;
      end
      if (cmd_i.worst_clear) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          worst_q[i] <= '0;
        end
      end else if (cmd_i.worst_raise) begin
        worst_q[addr_i] <= sec_q[addr_i];
      end
    end
  end

endmodule

>>> hdl/frame_section_profiler.sv
// frame_section_profiler: per-frame section profiler.
// in_i takes one request at a time (kind, slot, timer_now, show_worst); out_o
// returns exactly one result per request (slot_ticks, frame_total,
// overrun_count), read after that request's update. cfg_i writes the frame
// tick budget (index 0) and the grace frame count (index 1); it is always
// ready, and other indexes are ignored.
// A frame start request has the shared adder visit each slot twice, once to
// add it to the total and once to compare it with its worst value, then
// compare the total with the worst total and the budget; a frame in grace
// has no budget compare. A mark in range takes a subtract step and an add
// step, and anything else goes straight to the response step.
// The result sits in an output register; if out_o stalls, the sequencer
// waits in its response step until the register is free and in_i.ready stays low.
// Reset clears every slot, statistic and grace count and restores the
// register defaults (budget 4389, grace 20).
`include "frame_section_profiler_assert.svh"
module frame_section_profiler import fsp_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fsp_in_if.sink     in_i,
  fsp_out_if.source  out_o,
  fsp_cfg_if.sink    cfg_i
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned SUM_W = TICK_W + $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_MARK_SUB = 8'b0000_0010,
    ST_MARK_ADD = 8'b0000_0100,
    ST_SCAN_ADD = 8'b0000_1000,
    ST_SCAN_CMP = 8'b0001_0000,
    ST_TOT_CMP  = 8'b0010_0000,
    ST_BUD_CMP  = 8'b0100_0000,
    ST_RESP     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // latched request
  logic [2:0]        kind_q;
  logic [3:0]        slot_q;
  logic [TICK_W-1:0] now_q;
  logic              show_worst_q;
  logic              slot_ok_q;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SUM_W-1:0]  acc_q, acc_d;
  logic [TICK_W-1:0] tmp_q, tmp_d;

  logic [TICK_W-1:0]  last_q, last_d;
  logic [TICK_W-1:0]  worst_total_q, worst_total_d;
  logic [TICK_W-1:0]  overruns_q, overruns_d;
  logic [TICK_W-1:0]  prev_sum_q, prev_sum_d;
  logic [GRACE_W-1:0] grace_q, grace_d;
  logic [TICK_W-1:0]  budget_q;
  logic [GRACE_W-1:0] grace_cfg_q;

  fsp_out_t out_q;
  logic     out_valid_q;
  logic     out_load;

  logic in_acc;
  logic cfg_acc;
  logic slot_ok_in;
  logic clear_stats;

  alu_op_e           alu_op;
  logic [SUM_W-1:0]  alu_a, alu_b, alu_res;
  logic              alu_carry;

  bank_cmd_t         bank_cmd;
  logic [IDX_W-1:0]  bank_addr;
  logic [TICK_W-1:0] sec_wdata;
  logic [TICK_W-1:0] sec_rd, prev_rd, worst_rd;

  assign in_acc     = in_i.valid && in_i.ready;
  assign cfg_acc    = cfg_i.valid && cfg_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign slot_ok_in = ({28'd0, in_i.data.slot} < 32'(SLOT_COUNT));

  assign bank_addr = (state_q == ST_SCAN_ADD || state_q == ST_SCAN_CMP) ?
                     idx_q : slot_q[IDX_W-1:0];

  fsp_alu #(
    .W (SUM_W)
  ) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  fsp_slot_bank #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (bank_cmd),
    .addr_i      (bank_addr),
    .sec_wdata_i (sec_wdata),
    .sec_o       (sec_rd),
    .prev_o      (prev_rd),
    .worst_o     (worst_rd)
  );

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    acc_d         = acc_q;
    tmp_d         = tmp_q;
    last_d        = last_q;
    worst_total_d = worst_total_q;
    overruns_d    = overruns_q;
    prev_sum_d    = prev_sum_q;
    grace_d       = grace_q;
    alu_op        = ALU_ADD;
    alu_a         = '0;
    alu_b         = '0;
    bank_cmd      = '0;
    sec_wdata     = alu_res[TICK_W-1:0];
    clear_stats   = 1'b0;
    out_load      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_i.data.kind)
            KIND_FRAME: begin
              state_d = ST_SCAN_ADD;
              idx_d   = '0;
              acc_d   = '0;
            end
            KIND_MARK: begin
              state_d = slot_ok_in ? ST_MARK_SUB : ST_RESP;
            end
            KIND_LEVEL: begin
              grace_d     = grace_cfg_q;
              clear_stats = 1'b1;
              state_d     = ST_RESP;
            end
            KIND_CLEAR: begin
              clear_stats = 1'b1;
              state_d     = ST_RESP;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_MARK_SUB: begin
        alu_op  = ALU_SUB;
        alu_a   = SUM_W'(now_q);
        alu_b   = SUM_W'(last_q);
        tmp_d   = alu_res[TICK_W-1:0];
        state_d = ST_MARK_ADD;
      end
      ST_MARK_ADD: begin
        alu_op          = ALU_ADD;
        alu_a           = SUM_W'(sec_rd);
        alu_b           = SUM_W'(tmp_q);
        bank_cmd.sec_wr = 1'b1;
        last_d          = now_q;
        state_d         = ST_RESP;
      end
      ST_SCAN_ADD: begin
        alu_op  = ALU_ADD;
        alu_a   = acc_q;
        alu_b   = SUM_W'(sec_rd);
        acc_d   = alu_res;
        state_d = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        // no carry: section value above its worst
        alu_op               = ALU_SUB;
        alu_a                = SUM_W'(worst_rd);
        alu_b                = SUM_W'(sec_rd);
        bank_cmd.frame_move  = 1'b1;
        bank_cmd.worst_raise = (grace_q == '0) && !alu_carry;
        if (idx_q == LAST_IDX) begin
          state_d = ST_TOT_CMP;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_SCAN_ADD;
        end
      end
      ST_TOT_CMP: begin
        last_d     = '0;
        prev_sum_d = acc_q[TICK_W-1:0];
        alu_op     = ALU_SUB;
        alu_a      = SUM_W'(worst_total_q);
        alu_b      = acc_q;
        if (grace_q == '0) begin
          if (!alu_carry) begin
            worst_total_d = acc_q[TICK_W-1:0];
          end
          state_d = ST_BUD_CMP;
        end else begin
          grace_d = grace_q - GRACE_W'(1);
          state_d = ST_RESP;
        end
      end
      ST_BUD_CMP: begin
        alu_op = ALU_SUB;
        alu_a  = SUM_W'(budget_q);
        alu_b  = acc_q;
        if (!alu_carry) begin
          overruns_d = overruns_q + TICK_W'(1);
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (clear_stats) begin
      worst_total_d        = '0;
      overruns_d           = '0;
      bank_cmd.worst_clear = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      last_q        <= '0;
      worst_total_q <= '0;
      overruns_q    <= '0;
      prev_sum_q    <= '0;
      grace_q       <= '0;
      budget_q      <= BUDGET_RESET;
      grace_cfg_q   <= GRACE_RESET;
    end else begin
      state_q       <= state_d;
      last_q        <= last_d;
      worst_total_q <= worst_total_d;
      overruns_q    <= overruns_d;
      prev_sum_q    <= prev_sum_d;
      grace_q       <= grace_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_acc) begin
        if (cfg_i.data.addr == CFG_BUDGET) begin
          budget_q <= cfg_i.data.wdata;
        end else if (cfg_i.data.addr == CFG_GRACE) begin
          grace_cfg_q <= cfg_i.data.wdata[GRACE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    acc_q <= acc_d;
    tmp_q <= tmp_d;
    if (in_acc) begin
      kind_q       <= in_i.data.kind;
      slot_q       <= in_i.data.slot;
      now_q        <= in_i.data.timer_now;
      show_worst_q <= in_i.data.show_worst;
      slot_ok_q    <= slot_ok_in;
    end
    if (out_load) begin
      out_q.slot_ticks    <= !slot_ok_q ? '0 : (show_worst_q ? worst_rd : prev_rd);
      out_q.frame_total   <= show_worst_q ? worst_total_q : prev_sum_q;
      out_q.overrun_count <= overruns_q;
    end
  end

  `FSP_ASSERT(a_frame_starts_scan,
              (in_acc && in_i.data.kind == KIND_FRAME) |=>
              (state_q == ST_SCAN_ADD && idx_q == '0))
  `FSP_ASSERT(a_resp_waits,
              (state_q == ST_RESP && out_valid_q && !out_o.ready) |=>
              (state_q == ST_RESP && kind_q == $past(kind_q)))
  `FSP_ASSERT(a_overrun_source,
              !$stable(overruns_q) |-> ($past(state_q) == ST_BUD_CMP || $past(clear_stats)))
  `FSP_ASSERT(a_grace_countdown,
              (state_q == ST_TOT_CMP && grace_q != '0) |=>
              (grace_q == $past(grace_q) - GRACE_W'(1)))
  `FSP_ASSERT_NEVER(a_no_write_bad_slot, bank_cmd.sec_wr && !slot_ok_q)

endmodule
